[hdl/vn_pkg.sv]
// Shared constants for the vector normalisation core.
`timescale 1ns / 1ps
`default_nettype none
package vn_pkg;
  localparam int IN_WIDTH_DEF = 24;
  localparam int OUT_FRAC_DEF = 22;
  // Fraction bits carried by the norm.
  localparam int NORM_FRAC    = 8;
endpackage
`default_nettype wire

[hdl/vn_sqrt_pipe.sv]
// Pipelined digit-by-digit square root: one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module vn_sqrt_pipe #(
  parameter int IN_WIDTH = vn_pkg::IN_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic [2*IN_WIDTH-1:0]                  sum_in,
  output logic      [IN_WIDTH+vn_pkg::NORM_FRAC-1:0]  norm_out
);
  localparam int SW  = 2 * IN_WIDTH;
  localparam int NW  = IN_WIDTH + vn_pkg::NORM_FRAC;
  localparam int RMW = NW + 2;

  logic [RMW-1:0] rem_r  [0:NW-1];
  logic [NW-1:0]  root_r [0:NW-1];
  logic [SW-1:0]  sum_r  [0:NW-1];

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic [RMW-1:0] rem_i;
    logic [NW-1:0]  root_i;
    logic [SW-1:0]  sum_i;
    logic [1:0]     pair;
    logic [RMW-1:0] shifted;
    logic [RMW-1:0] trial;
    if (g == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign sum_i  = sum_in;
    end else begin : g_next
      assign rem_i  = rem_r[g-1];
      assign root_i = root_r[g-1];
      assign sum_i  = sum_r[g-1];
    end
    // The low radicand digits are the zero fraction pairs of the shifted sum.
    if (g < IN_WIDTH) begin : g_pair
      assign pair = sum_i[SW-1-2*g -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end
    assign shifted = {rem_i[RMW-3:0], pair};
    assign trial   = {root_i, 2'b01};
    always_ff @(posedge clk) begin
      sum_r[g] <= sum_i;
      if (shifted >= trial) begin
        rem_r[g]  <= shifted - trial;
        root_r[g] <= {root_i[NW-2:0], 1'b1};
      end else begin
        rem_r[g]  <= shifted;
        root_r[g] <= {root_i[NW-2:0], 1'b0};
      end
    end
  end

  assign norm_out = root_r[NW-1];
endmodule
`default_nettype wire

[hdl/vn_div_lane.sv]
// One division lane: pipelined restoring divide of a magnitude by the norm.
`timescale 1ns / 1ps
`default_nettype none
module vn_div_lane #(
  parameter int IN_WIDTH = vn_pkg::IN_WIDTH_DEF,
  parameter int OUT_FRAC = vn_pkg::OUT_FRAC_DEF
) (
  input  wire logic                                  clk,
  input  wire logic [IN_WIDTH-1:0]                   mag_in,
  input  wire logic                                  neg_in,
  input  wire logic [IN_WIDTH+vn_pkg::NORM_FRAC-1:0] norm_in,
  output logic      [OUT_FRAC:0]                     quot_out,
  output logic                                       neg_out
);
  localparam int NW = IN_WIDTH + vn_pkg::NORM_FRAC;
  localparam int QW = OUT_FRAC + 1;

  logic [NW:0]   rem_r  [0:QW-1];
  logic [QW-1:0] q_r    [0:QW-1];
  logic [NW-1:0] norm_r [0:QW-1];
  logic          neg_r  [0:QW-1];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic [NW:0]   part;
    logic [QW-1:0] q_i;
    logic [NW-1:0] norm_i;
    logic          neg_i;
    // The first step starts from the magnitude aligned to the norm's fraction.
    if (g == 0) begin : g_first
      assign part   = {1'b0, mag_in, {vn_pkg::NORM_FRAC{1'b0}}};
      assign q_i    = '0;
      assign norm_i = norm_in;
      assign neg_i  = neg_in;
    end else begin : g_next
      assign part   = {rem_r[g-1][NW-1:0], 1'b0};
      assign q_i    = q_r[g-1];
      assign norm_i = norm_r[g-1];
      assign neg_i  = neg_r[g-1];
    end
    always_ff @(posedge clk) begin
      norm_r[g] <= norm_i;
      neg_r[g]  <= neg_i;
      if (part >= {1'b0, norm_i}) begin
        rem_r[g] <= part - {1'b0, norm_i};
        q_r[g]   <= {q_i[QW-2:0], 1'b1};
      end else begin
        rem_r[g] <= part;
        q_r[g]   <= {q_i[QW-2:0], 1'b0};
      end
    end
  end

  assign quot_out = q_r[QW-1];
  assign neg_out  = neg_r[QW-1];
endmodule
`default_nettype wire

[hdl/vector3_normalize_core.sv]
// Top level: squares, sum, shared square root and three division lanes.
// Words pass the squares, the sum, the root pipeline, the lanes and the output register.
// One word is taken every cycle; busy is never raised, as the pipeline holds no hazard.
// The root pipeline gives one bit per stage and each lane one quotient bit per stage.
// Reset (synchronous, rst_n low) clears only the valid chain; no result is then pending.
// The receiver cannot stall: each result stands on the out_ ports for one cycle.
`timescale 1ns / 1ps
`default_nettype none
module vector3_normalize_core #(
  parameter int IN_WIDTH = vn_pkg::IN_WIDTH_DEF,
  parameter int OUT_FRAC = vn_pkg::OUT_FRAC_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic signed [IN_WIDTH-1:0] in_comp_x,
  input  wire logic signed [IN_WIDTH-1:0] in_comp_y,
  input  wire logic signed [IN_WIDTH-1:0] in_comp_z,
  output logic                            out_valid,
  output logic signed [OUT_FRAC+1:0]      out_unit_x,
  output logic signed [OUT_FRAC+1:0]      out_unit_y,
  output logic signed [OUT_FRAC+1:0]      out_unit_z,
  output logic                            out_zero_vector
);
  localparam int NW  = IN_WIDTH + vn_pkg::NORM_FRAC;
  localparam int QW  = OUT_FRAC + 1;
  localparam int SW  = 2 * IN_WIDTH;
  localparam int DL  = NW + QW;
  localparam int LAT = 3 + NW + QW;

  logic [IN_WIDTH-1:0] comp   [0:2];
  logic [IN_WIDTH-1:0] mag_a_r[0:2];
  logic                neg_a_r[0:2];
  logic [SW-1:0]       sq_a_r [0:2];
  logic                va_r, va_nxt;
  logic [IN_WIDTH-1:0] mag_b_r[0:2];
  logic                neg_b_r[0:2];
  logic [SW-1:0]       sum_b_r;
  logic                zero_b_r;
  logic                vb_r;
  logic [IN_WIDTH-1:0] mag_d_r[0:2][0:NW-1];
  logic                neg_d_r[0:2][0:NW-1];
  logic                zero_d_r[0:DL-1];
  logic                vld_d_r [0:DL-1];
  logic [NW-1:0]       norm;
  logic [QW-1:0]       quot[0:2];
  logic                qneg[0:2];
  logic [OUT_FRAC+1:0] unit_nxt[0:2];
  logic [OUT_FRAC+1:0] unit_r  [0:2];
  logic                zero_r, out_valid_r;

  assign busy    = 1'b0;
  assign va_nxt  = start && !busy;
  assign comp[0] = in_comp_x;
  assign comp[1] = in_comp_y;
  assign comp[2] = in_comp_z;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic [IN_WIDTH-1:0] mag_i;
    assign mag_i = comp[k][IN_WIDTH-1] ? (~comp[k] + 1'b1) : comp[k];
    always_ff @(posedge clk) begin
      mag_a_r[k] <= mag_i;
      neg_a_r[k] <= comp[k][IN_WIDTH-1];
      sq_a_r[k]  <= SW'(mag_i) * SW'(mag_i);
      mag_b_r[k] <= mag_a_r[k];
      neg_b_r[k] <= neg_a_r[k];
      mag_d_r[k][0] <= mag_b_r[k];
      neg_d_r[k][0] <= neg_b_r[k];
      for (int s = 1; s < NW; s++) begin
        mag_d_r[k][s] <= mag_d_r[k][s-1];
        neg_d_r[k][s] <= neg_d_r[k][s-1];
      end
    end

    vn_div_lane #(
      .IN_WIDTH(IN_WIDTH),
      .OUT_FRAC(OUT_FRAC)
    ) u_lane (
      .clk     (clk),
      .mag_in  (mag_d_r[k][NW-1]),
      .neg_in  (neg_d_r[k][NW-1]),
      .norm_in (norm),
      .quot_out(quot[k]),
      .neg_out (qneg[k])
    );

    // Apply the sign to the unsigned quotient; a zero vector forces zero.
    always_comb begin
      if (zero_d_r[DL-1]) begin
        unit_nxt[k] = '0;
      end else if (qneg[k]) begin
        unit_nxt[k] = ~{1'b0, quot[k]} + 1'b1;
      end else begin
        unit_nxt[k] = {1'b0, quot[k]};
      end
    end

    always_ff @(posedge clk) begin
      unit_r[k] <= unit_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    sum_b_r  <= sq_a_r[0] + sq_a_r[1] + sq_a_r[2];
    zero_b_r <= (sq_a_r[0] == '0) && (sq_a_r[1] == '0) && (sq_a_r[2] == '0);
    zero_d_r[0] <= zero_b_r;
    for (int s = 1; s < DL; s++) begin
      zero_d_r[s] <= zero_d_r[s-1];
    end
    zero_r <= zero_d_r[DL-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < DL; s++) begin
        vld_d_r[s] <= 1'b0;
      end
    end else begin
      va_r        <= va_nxt;
      vb_r        <= va_r;
      vld_d_r[0]  <= vb_r;
      for (int s = 1; s < DL; s++) begin
        vld_d_r[s] <= vld_d_r[s-1];
      end
      out_valid_r <= vld_d_r[DL-1];
    end
  end

  vn_sqrt_pipe #(
    .IN_WIDTH(IN_WIDTH)
  ) u_sqrt (
    .clk     (clk),
    .sum_in  (sum_b_r),
    .norm_out(norm)
  );

  assign out_valid       = out_valid_r;
  assign out_unit_x      = unit_r[0];
  assign out_unit_y      = unit_r[1];
  assign out_unit_z      = unit_r[2];
  assign out_zero_vector = zero_r;

  a_zero_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_vector |-> out_unit_x == '0 && out_unit_y == '0 &&
    out_unit_z == '0) else $error("zero vector gave a non-zero word");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LAT out_valid) else $error("word lost in the pipeline");

  a_range_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_unit_x <= $signed({2'b01, {OUT_FRAC{1'b0}}}) &&
    out_unit_x >= -$signed({2'b01, {OUT_FRAC{1'b0}}}))
    else $error("x component above unit length");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r && zero_b_r |-> sum_b_r == '0) else $error("zero flag without zero sum");
endmodule
`default_nettype wire

[sim/tb_vector3_normalize_core.sv]
// Self-checking testbench for the vector normalisation core.
`timescale 1ns / 1ps
module tb_vector3_normalize_core;

  localparam int IW = vn_pkg::IN_WIDTH_DEF;
  localparam int OW = vn_pkg::OUT_FRAC_DEF + 2;
  localparam int LATENCY = 3 + (IW + vn_pkg::NORM_FRAC) + (vn_pkg::OUT_FRAC_DEF + 1);
  localparam int WATCHDOG_LIMIT = 20 * LATENCY + 2000;
  localparam int N_RANDOM = 400;

  typedef struct packed {
    logic signed [OW-1:0] ux;
    logic signed [OW-1:0] uy;
    logic signed [OW-1:0] uz;
    logic                 zv;
  } unit_vec_t;

  typedef struct {
    logic signed [IW-1:0] cx;
    logic signed [IW-1:0] cy;
    logic signed [IW-1:0] cz;
    bit                   known;
    unit_vec_t            res;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [IW-1:0] in_comp_x = '0;
  logic signed [IW-1:0] in_comp_y = '0;
  logic signed [IW-1:0] in_comp_z = '0;
  logic out_valid;
  logic signed [OW-1:0] out_unit_x, out_unit_y, out_unit_z;
  logic out_zero_vector;

  unit_vec_t pending_units[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_zero = 0;
  int idle_cycles = 0;
  int send_gap_pct = 0;

  vector3_normalize_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_comp_x(in_comp_x), .in_comp_y(in_comp_y), .in_comp_z(in_comp_z),
    .out_valid(out_valid), .out_unit_x(out_unit_x), .out_unit_y(out_unit_y),
    .out_unit_z(out_unit_z), .out_zero_vector(out_zero_vector)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] abs_comp(input logic signed [IW-1:0] c);
    logic [IW-1:0] u;
    u = c;
    if (u[IW-1]) u = ~u + 1'b1;
    return 64'(u);
  endfunction

  // Floor square root of the sum of squares with NORM_FRAC fraction bits.
  function automatic logic [63:0] length_q8(input logic [63:0] s);
    logic [127:0] v;
    logic [63:0] r;
    v = {64'd0, s} << (2 * vn_pkg::NORM_FRAC);
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      logic [63:0] t;
      t = r | (64'd1 << b);
      if (128'(t) * 128'(t) <= v) r = t;
    end
    return r;
  endfunction

  function automatic unit_vec_t normalise(input logic signed [IW-1:0] cx,
                                          input logic signed [IW-1:0] cy,
                                          input logic signed [IW-1:0] cz);
    logic [63:0] m [3];
    logic [63:0] sum, len;
    logic [127:0] q;
    logic [OW-1:0] o [3];
    unit_vec_t r;
    m[0] = abs_comp(cx);
    m[1] = abs_comp(cy);
    m[2] = abs_comp(cz);
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    if (sum == 0) begin
      r = '{ux: '0, uy: '0, uz: '0, zv: 1'b1};
      return r;
    end
    len = length_q8(sum);
    for (int i = 0; i < 3; i++) begin
      q = (128'(m[i]) << (vn_pkg::OUT_FRAC_DEF + vn_pkg::NORM_FRAC)) / 128'(len);
      o[i] = q[OW-1:0];
    end
    if (cx[IW-1]) o[0] = -o[0];
    if (cy[IW-1]) o[1] = -o[1];
    if (cz[IW-1]) o[2] = -o[2];
    r = '{ux: o[0], uy: o[1], uz: o[2], zv: 1'b0};
    return r;
  endfunction

  // Result checker: outputs are sampled at the edge that ends the strobe cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      unit_vec_t want;
      if (pending_units.size() == 0) begin
        $display("%0t: unexpected word x=%0d y=%0d z=%0d zero=%0b", $time,
                 out_unit_x, out_unit_y, out_unit_z, out_zero_vector);
        errors++;
      end else begin
        want = pending_units.pop_front();
        n_checked++;
        if (want.zv) n_zero++;
        if (out_unit_x !== want.ux) begin
          $display("%0t: unit_x expected %0d got %0d", $time, want.ux, out_unit_x);
          errors++;
        end
        if (out_unit_y !== want.uy) begin
          $display("%0t: unit_y expected %0d got %0d", $time, want.uy, out_unit_y);
          errors++;
        end
        if (out_unit_z !== want.uz) begin
          $display("%0t: unit_z expected %0d got %0d", $time, want.uz, out_unit_z);
          errors++;
        end
        if (out_zero_vector !== want.zv) begin
          $display("%0t: zero_vector expected %0b got %0b", $time, want.zv,
                   out_zero_vector);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no word moving in either direction.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Holds start for one accepted word, with random gaps ahead of it. Start is
  // left high afterwards so that back-to-back words need no second drive.
  task automatic send_vector(input logic signed [IW-1:0] cx,
                             input logic signed [IW-1:0] cy,
                             input logic signed [IW-1:0] cz,
                             input unit_vec_t want);
    while ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_comp_x <= cx;
    in_comp_y <= cy;
    in_comp_z <= cz;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_units.push_back(want);
    n_sent++;
  endtask

  function automatic logic signed [IW-1:0] rand_comp(input int mode);
    logic [31:0] r;
    r = $urandom;
    case (mode)
      0: return r[IW-1:0];
      1: return IW'($signed(r[7:0]));
      2: return IW'($signed(r[15:0]));
      default: return r[0] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    endcase
  endfunction

  localparam logic signed [IW-1:0] MAXP = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] MAXN = {1'b1, {(IW-1){1'b0}}};
  localparam logic signed [OW-1:0] ONE  = OW'(1) <<< vn_pkg::OUT_FRAC_DEF;

  vec_row_t directed[] = '{
    '{0, 0, 0, 1, '{ux: 0, uy: 0, uz: 0, zv: 1}},
    '{1, 0, 0, 1, '{ux: ONE, uy: 0, uz: 0, zv: 0}},
    '{0, -1, 0, 1, '{ux: 0, uy: -ONE, uz: 0, zv: 0}},
    '{0, 0, MAXP, 1, '{ux: 0, uy: 0, uz: ONE, zv: 0}},
    '{MAXN, 0, 0, 1, '{ux: -ONE, uy: 0, uz: 0, zv: 0}},
    '{0, MAXN, 0, 1, '{ux: 0, uy: -ONE, uz: 0, zv: 0}},
    '{0, 0, MAXN, 1, '{ux: 0, uy: 0, uz: -ONE, zv: 0}},
    '{MAXP, MAXP, MAXP, 0, '{default: 0}},
    '{MAXN, MAXN, MAXN, 0, '{default: 0}},
    '{MAXN, MAXP, MAXN, 0, '{default: 0}},
    '{1, 1, 1, 0, '{default: 0}},
    '{-1, -1, -1, 0, '{default: 0}},
    '{3, 4, 0, 0, '{default: 0}},
    '{MAXP, 1, 0, 0, '{default: 0}},
    '{1, MAXN, -1, 0, '{default: 0}},
    '{24'h555555, -24'sh2aaaab, 24'h0f0f0f, 0, '{default: 0}}
  };

  initial begin
    int phase;
    vec_row_t row;
    logic signed [IW-1:0] rx, ry, rz;
    int mode;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      row = directed[i];
      if (row.known) begin
        if (normalise(row.cx, row.cy, row.cz) !== row.res) begin
          $display("%0t: table row %0d disagrees with predictor", $time, i);
          errors++;
        end
        send_vector(row.cx, row.cy, row.cz, row.res);
      end else begin
        send_vector(row.cx, row.cy, row.cz, normalise(row.cx, row.cy, row.cz));
      end
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      phase = n / 80;
      case (phase)
        0: send_gap_pct = 0;
        1: send_gap_pct = 58;
        2: send_gap_pct = 30;
        3: send_gap_pct = 58;
        default: send_gap_pct = 0;
      endcase
      // Let the pipeline drain completely once, mid-run.
      if (n == 200) begin
        start <= 1'b0;
        while (pending_units.size() != 0) @(posedge clk);
      end
      mode = $urandom_range(9);
      if (mode == 9) begin
        rx = 0; ry = 0; rz = 0;
        case ($urandom_range(3))
          0: rx = rand_comp(0);
          1: ry = rand_comp(1);
          2: rz = rand_comp(3);
          default: ;
        endcase
      end else begin
        mode = mode % 4;
        rx = rand_comp(mode);
        ry = rand_comp($urandom_range(3));
        rz = rand_comp(mode);
      end
      send_vector(rx, ry, rz, normalise(rx, ry, rz));
    end

    start <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);

    $display("Sent %0d vectors and checked %0d results, %0d of them zero vectors,",
             n_sent, n_checked, n_zero);
    $display("covering extremes, single-axis cases and random gaps on the input.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

[files.f]
hdl/vn_pkg.sv
hdl/vn_sqrt_pipe.sv
hdl/vn_div_lane.sv
hdl/vector3_normalize_core.sv
sim/tb_vector3_normalize_core.sv
